### hw/rtl/plst_pkg.sv
`timescale 1ns / 1ps

package plst_pkg;

	// Field widths fixed by the request and response formats.
	localparam int CMD_W  = 2;
	localparam int POS_W  = 8;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	localparam int LEN_W  = 7;

	// Default list capacity.
	localparam int DEPTH_DEF = 64;

	// Packed stream widths, rounded up to whole bytes.
	localparam int IN_BITS  = CMD_W + 2 * POS_W + DATA_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = STAT_W + DATA_W + LEN_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_ERASE  = 2'd1,
		CMD_SWAP   = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Operation broadcast to every cell of the chain.
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_ERASE  = 2'd2,
		CELL_SWAP   = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [POS_W-1:0]  pos_a;
		logic [POS_W-1:0]  pos_b;
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] val_a;
		logic [DATA_W-1:0] val_b;
	} cell_ctl_t;

endpackage

### hw/rtl/plst_cell.sv
`timescale 1ns / 1ps

// One list slot. POS is the 1-based position this cell holds.
module plst_cell
	import plst_pkg::*;
#(
	parameter int POS = 1
) (
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [DATA_W-1:0] left,
	input  logic [DATA_W-1:0] right,
	output logic [DATA_W-1:0] data
);

	localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		unique case (ctl.op)
			CELL_INSERT: begin
				if (MY_POS > ctl.pos_a) begin
					data_d = left;
				end else if (MY_POS == ctl.pos_a) begin
					data_d = ctl.value;
				end
			end
			CELL_ERASE: begin
				if (MY_POS >= ctl.pos_a) begin
					data_d = right;
				end
			end
			CELL_SWAP: begin
				if (MY_POS == ctl.pos_a) begin
					data_d = ctl.val_b;
				end else if (MY_POS == ctl.pos_b) begin
					data_d = ctl.val_a;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

### hw/rtl/plst_select.sv
`timescale 1ns / 1ps

// Picks the cell at a 1-based position with a one-hot AND-OR tree.
module plst_select
	import plst_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic [DATA_W-1:0] cells [DEPTH],
	input  logic [POS_W-1:0]  pos,
	output logic [DATA_W-1:0] sel
);

	always_comb begin
		sel = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (pos == POS_W'(i + 1)) begin
				sel = sel | cells[i];
			end
		end
	end

endmodule

### hw/rtl/positional_list_engine.sv
`timescale 1ns / 1ps

// Positional list engine: keeps an ordered list of up to DEPTH signed 32-bit
// values in a chain of cells, one cell per position, and serves insert,
// erase, swap and read requests addressed by 1-based position. Each input
// transaction yields exactly one output transaction carrying a status (done,
// position out of range, or list full), the value read (zero unless the
// request was a successful read) and the list length after the request.
// One request is handled at a time, in steps: it is accepted, then the
// positions are checked and the addressed cells are picked through the
// select trees, and last every cell shifts or swaps with its neighbors in
// parallel. The output register lets a new request be accepted while the
// previous result is still waiting to be taken; a result that cannot be
// presented holds the engine in its final step until the output drains.
// List contents are not cleared by reset; only the length is, so positions
// beyond the length are never read.
module positional_list_engine
	import plst_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,

	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// [1:0] command, [9:2] pos_a, [17:10] pos_b, [49:18] value, rest zero
	input  logic [IN_W-1:0]  s_axis_tdata,

	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// [1:0] status, [33:2] read_value, [40:34] length, rest zero
	output logic [OUT_W-1:0] m_axis_tdata
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	// One-hot sequencer states.
	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_FETCH = 3'b010,
		S_APPLY = 3'b100
	} state_t;

	state_t state_q;

	// Latched request.
	cmd_t              cmd_q;
	logic [POS_W-1:0]  pos_a_q;
	logic [POS_W-1:0]  pos_b_q;
	logic [DATA_W-1:0] value_q;

	// Results of the check step.
	status_t           status_q;
	logic [DATA_W-1:0] rd_a_q;
	logic [DATA_W-1:0] rd_b_q;

	logic [CNT_W-1:0]  count_q;

	// Output register.
	logic              out_valid_q;
	status_t           out_status_q;
	logic [DATA_W-1:0] out_rd_q;
	logic [LEN_W-1:0]  out_len_q;

	logic [DATA_W-1:0] cell_data [DEPTH];
	logic [DATA_W-1:0] sel_a;
	logic [DATA_W-1:0] sel_b;
	cell_ctl_t         ctl;

	logic              in_acc;
	logic              out_free;
	logic              a_bad_ins;
	logic              a_bad;
	logic              b_bad;
	logic              full;
	status_t           status_d;
	logic [CNT_W-1:0]  count_next;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	// Range checks against the current length. Position zero fails every
	// check; an insert may also target the slot just past the end.
	assign a_bad_ins = (pos_a_q == '0) ||
		(CMP_W'(pos_a_q) > (CMP_W'(count_q) + CMP_W'(1)));
	assign a_bad     = (pos_a_q == '0) || (CMP_W'(pos_a_q) > CMP_W'(count_q));
	assign b_bad     = (pos_b_q == '0) || (CMP_W'(pos_b_q) > CMP_W'(count_q));
	assign full      = (count_q == CNT_W'(DEPTH));

	always_comb begin
		unique case (cmd_q)
			CMD_INSERT: status_d = a_bad_ins ? ST_RANGE : (full ? ST_FULL : ST_DONE);
			CMD_ERASE:  status_d = a_bad ? ST_RANGE : ST_DONE;
			CMD_SWAP:   status_d = (a_bad || b_bad) ? ST_RANGE : ST_DONE;
			CMD_READ:   status_d = a_bad ? ST_RANGE : ST_DONE;
			default:    status_d = ST_RANGE;
		endcase
	end

	// The cells change only in the final step of a successful request.
	always_comb begin
		ctl.pos_a = pos_a_q;
		ctl.pos_b = pos_b_q;
		ctl.value = value_q;
		ctl.val_a = rd_a_q;
		ctl.val_b = rd_b_q;
		ctl.op    = CELL_HOLD;
		if (state_q == S_APPLY && out_free && status_q == ST_DONE) begin
			unique case (cmd_q)
				CMD_INSERT: ctl.op = CELL_INSERT;
				CMD_ERASE:  ctl.op = CELL_ERASE;
				CMD_SWAP:   ctl.op = (pos_a_q != pos_b_q) ? CELL_SWAP : CELL_HOLD;
				CMD_READ:   ctl.op = CELL_HOLD;
				default:    ctl.op = CELL_HOLD;
			endcase
		end
	end

	always_comb begin
		count_next = count_q;
		if (status_q == ST_DONE) begin
			if (cmd_q == CMD_INSERT) begin
				count_next = count_q + CNT_W'(1);
			end else if (cmd_q == CMD_ERASE) begin
				count_next = count_q - CNT_W'(1);
			end
		end
	end

	// The chain: each cell sees its left and right neighbors; the ends see
	// zeros, which only ever land in slots past the end of the list.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] left_data;
		logic [DATA_W-1:0] right_data;

		if (i == 0) begin : g_first
			assign left_data = '0;
		end else begin : g_mid_l
			assign left_data = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_data = '0;
		end else begin : g_mid_r
			assign right_data = cell_data[i+1];
		end

		plst_cell #(
			.POS(i + 1)
		) u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.left (left_data),
			.right(right_data),
			.data (cell_data[i])
		);
	end

	plst_select #(
		.DEPTH(DEPTH)
	) u_sel_a (
		.cells(cell_data),
		.pos  (pos_a_q),
		.sel  (sel_a)
	);

	plst_select #(
		.DEPTH(DEPTH)
	) u_sel_b (
		.cells(cell_data),
		.pos  (pos_b_q),
		.sel  (sel_b)
	);

	// Sequencer, length counter and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result takes precedence over the one being drained.
			if (state_q == S_APPLY && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (out_free) begin
						count_q <= count_next;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q   <= cmd_t'(s_axis_tdata[CMD_W-1:0]);
			pos_a_q <= s_axis_tdata[CMD_W +: POS_W];
			pos_b_q <= s_axis_tdata[CMD_W+POS_W +: POS_W];
			value_q <= s_axis_tdata[CMD_W+2*POS_W +: DATA_W];
		end
		if (state_q == S_FETCH) begin
			status_q <= status_d;
			rd_a_q   <= sel_a;
			rd_b_q   <= sel_b;
		end
		if (state_q == S_APPLY && out_free) begin
			out_status_q <= status_q;
			out_rd_q     <= (cmd_q == CMD_READ && status_q == ST_DONE) ? rd_a_q : '0;
			out_len_q    <= LEN_W'(count_next);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, out_len_q, out_rd_q, out_status_q};

endmodule

### verif/list_engine_checker.sv
`timescale 1ns / 1ps

// Watches both stream ports of the list engine. It keeps its own copy of the
// list, works out the reply to every accepted request and compares each
// accepted reply with the oldest outstanding one.
module list_engine_checker
	import plst_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,

	input  logic             s_axis_tvalid,
	input  logic             s_axis_tready,
	// [1:0] command, [9:2] pos_a, [17:10] pos_b, [49:18] value, rest zero
	input  logic [IN_W-1:0]  s_axis_tdata,

	input  logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// [1:0] status, [33:2] read_value, [40:34] length, rest zero
	input  logic [OUT_W-1:0] m_axis_tdata,

	output int               mismatches,
	output int               replies
);

	typedef struct {
		status_t           status;
		logic [DATA_W-1:0] read_value;
		logic [LEN_W-1:0]  length;
	} list_reply_t;

	logic [DATA_W-1:0] cells [DEPTH];
	int                fill;
	list_reply_t       pending_replies [$];

	// Applies one request to the shadow list and returns the reply it earns.
	function automatic list_reply_t apply_request(cmd_t cmd, logic [POS_W-1:0] pos_a,
			logic [POS_W-1:0] pos_b, logic [DATA_W-1:0] value);
		list_reply_t       r;
		int                a;
		int                b;
		int                i;
		logic [DATA_W-1:0] t;
		a = pos_a;
		b = pos_b;
		r.status = ST_DONE;
		r.read_value = '0;
		case (cmd)
			CMD_INSERT: begin
				if (a < 1 || a > fill + 1) begin
					r.status = ST_RANGE;
				end else if (fill >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (i = fill; i > a - 1; i--)
						cells[i] = cells[i - 1];
					cells[a - 1] = value;
					fill++;
				end
			end
			CMD_ERASE: begin
				if (a < 1 || a > fill) begin
					r.status = ST_RANGE;
				end else begin
					for (i = a - 1; i + 1 < fill; i++)
						cells[i] = cells[i + 1];
					fill--;
				end
			end
			CMD_SWAP: begin
				if (a < 1 || b < 1 || a > fill || b > fill) begin
					r.status = ST_RANGE;
				end else if (a != b) begin
					t = cells[a - 1];
					cells[a - 1] = cells[b - 1];
					cells[b - 1] = t;
				end
			end
			default: begin
				if (a < 1 || a > fill)
					r.status = ST_RANGE;
				else
					r.read_value = cells[a - 1];
			end
		endcase
		r.length = LEN_W'(fill);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_reply_t       want;
		status_t           got_status;
		logic [DATA_W-1:0] got_value;
		logic [LEN_W-1:0]  got_length;
		logic [OUT_W-1:0]  got_pad;
		if (!arst_n) begin
			fill = 0;
			pending_replies.delete();
			mismatches <= 0;
			replies <= 0;
		end else begin
			// The reply leaving now always belongs to an earlier request, so it is
			// checked before this cycle's request is queued.
			if (m_axis_tvalid && m_axis_tready) begin
				replies <= replies + 1;
				got_status = status_t'(m_axis_tdata[1:0]);
				got_value  = m_axis_tdata[33:2];
				got_length = m_axis_tdata[40:34];
				got_pad    = m_axis_tdata >> OUT_BITS;
				if (pending_replies.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: reply with none outstanding: status %0d value %h len %0d",
							$realtime, got_status, got_value, got_length);
					mismatches <= mismatches + 1;
				end else begin
					want = pending_replies.pop_front();
					if (got_status !== want.status || got_value !== want.read_value ||
							got_length !== want.length || got_pad !== '0) begin
						if (mismatches < 10)
							$display({"%0t: reply mismatch: status %0d/%0d value %h/%h ",
								"len %0d/%0d pad %h (expected/actual)"}, $realtime,
								want.status, got_status, want.read_value, got_value,
								want.length, got_length, got_pad);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				pending_replies.push_back(apply_request(cmd_t'(s_axis_tdata[1:0]),
					s_axis_tdata[9:2], s_axis_tdata[17:10], s_axis_tdata[49:18]));
		end
	end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the positional list engine. The checker beside the
// block does all prediction and comparison; this module only shapes requests,
// throttles both ports and decides the outcome.
module tb;
	import plst_pkg::*;

	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 10;

	typedef enum {
		PH_GROW,
		PH_SHRINK,
		PH_CHURN,
		PH_NOISE
	} phase_kind_t;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;

	int mismatches;
	int replies;

	// Requests accepted so far, and the list length they should have left
	// behind; the length only steers positions toward the interesting range.
	int sent;
	int list_len;

	// Throttle controls for the sender and the receiver processes.
	bit send_gaps;
	bit take_gaps;
	bit hold_output;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	positional_list_engine DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	list_engine_checker u_list_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.mismatches   (mismatches),
		.replies      (replies)
	);

	// Offers one request, with an optional idle burst ahead of it, and returns
	// at the edge where the transaction is accepted. The valid is left high so
	// that back-to-back requests need no second assignment in the same step.
	task automatic send_request(cmd_t cmd, int pos_a, int pos_b, logic [DATA_W-1:0] value);
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_W - IN_BITS){1'b0}}, value, POS_W'(pos_b), POS_W'(pos_a), cmd};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
		if (cmd == CMD_INSERT && pos_a >= 1 && pos_a <= list_len + 1 && list_len < DEPTH_DEF)
			list_len++;
		else if (cmd == CMD_ERASE && pos_a >= 1 && pos_a <= list_len)
			list_len--;
	endtask

	// Stops offering and waits until every accepted request has been answered.
	task automatic wait_for_replies();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (replies != sent) @(posedge clk);
	endtask

	// Picks a position whose valid range is 1 to top. Most picks are valid,
	// with the ends favored; the rest fall just outside, at zero, or anywhere.
	function automatic int pick_pos(int top);
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return $urandom_range(0, 255);
		if (r < 11)
			return top + 1;
		if (r < 13 || top < 1)
			return (top < 1) ? $urandom_range(0, 2) : 0;
		if (r < 30)
			return ($urandom_range(0, 1) != 0) ? top : 1;
		return $urandom_range(1, top);
	endfunction

	// One stretch of random requests. Grow and shrink phases push the list to
	// full and to empty; noise sends fields with no regard for the length.
	task automatic random_phase(phase_kind_t kind, int items);
		int                n;
		int                r;
		cmd_t              cmd;
		logic [DATA_W-1:0] value;
		for (n = 0; n < items; n++) begin
			r = $urandom_range(0, 99);
			case (kind)
				PH_GROW:   cmd = (r < 60) ? CMD_INSERT : (r < 75) ? CMD_ERASE :
					(r < 85) ? CMD_SWAP : CMD_READ;
				PH_SHRINK: cmd = (r < 15) ? CMD_INSERT : (r < 75) ? CMD_ERASE :
					(r < 85) ? CMD_SWAP : CMD_READ;
				PH_CHURN:  cmd = (r < 30) ? CMD_INSERT : (r < 55) ? CMD_ERASE :
					(r < 75) ? CMD_SWAP : CMD_READ;
				default:   cmd = cmd_t'($urandom_range(0, 3));
			endcase
			case ($urandom_range(0, 9))
				0:       value = 32'h8000_0000;
				1:       value = 32'h7FFF_FFFF;
				default: value = $urandom();
			endcase
			if (kind == PH_NOISE)
				send_request(cmd, $urandom_range(0, 255), $urandom_range(0, 255), value);
			else if (cmd == CMD_INSERT)
				send_request(cmd, pick_pos(list_len + 1), $urandom_range(0, 255), value);
			else if (cmd == CMD_SWAP)
				send_request(cmd, pick_pos(list_len), pick_pos(list_len), value);
			else
				send_request(cmd, pick_pos(list_len), $urandom_range(0, 255), value);
		end
	endtask

	// Result side: short random stalls, or one long hold when asked for. The
	// long hold is counted here so the sender keeps pushing and the block
	// backs up into its input.
	initial begin
		int k;
		m_axis_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_output) begin
				hold_output = 1'b0;
				m_axis_tready <= 1'b0;
				for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
			end else if (take_gaps && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Safety net in case the block hangs.
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		phase_kind_t plan [11];
		int          p;
		plan = '{PH_GROW, PH_CHURN, PH_SHRINK, PH_NOISE, PH_GROW, PH_GROW, PH_SHRINK,
			PH_SHRINK, PH_CHURN, PH_GROW, PH_CHURN};
		sent          = 0;
		list_len      = 0;
		send_gaps     = 1'b1;
		take_gaps     = 1'b1;
		hold_output   = 1'b0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests: the empty list, position zero, both edges of every
		// range, extreme values, swaps in both orders and of equal positions.
		send_request(CMD_READ,   1, 0, $urandom());
		send_request(CMD_ERASE,  1, 0, $urandom());
		send_request(CMD_SWAP,   1, 1, $urandom());
		send_request(CMD_INSERT, 0, 0, 32'h1234_5678);
		send_request(CMD_INSERT, 2, 0, 32'h1234_5678);
		send_request(CMD_INSERT, 1, 0, 32'h8000_0000);
		send_request(CMD_INSERT, 2, 255, 32'h7FFF_FFFF);
		send_request(CMD_INSERT, 1, 0, 32'hFFFF_FFFF);
		send_request(CMD_INSERT, 4, 0, 32'h0000_0000);
		send_request(CMD_INSERT, 6, 0, 32'hA5A5_A5A5);
		send_request(CMD_READ,   0, 0, $urandom());
		send_request(CMD_READ,   4, 0, $urandom());
		send_request(CMD_READ,   5, 0, $urandom());
		send_request(CMD_SWAP,   1, 4, $urandom());
		send_request(CMD_SWAP,   4, 2, $urandom());
		send_request(CMD_SWAP,   3, 3, $urandom());
		send_request(CMD_SWAP,   0, 2, $urandom());
		send_request(CMD_SWAP,   2, 5, $urandom());
		send_request(CMD_READ,   255, 255, $urandom());
		send_request(CMD_ERASE,  0, 0, $urandom());
		send_request(CMD_ERASE,  5, 0, $urandom());
		send_request(CMD_ERASE,  4, 0, $urandom());
		send_request(CMD_ERASE,  1, 0, $urandom());
		send_request(CMD_READ,   1, 0, $urandom());
		send_request(CMD_READ,   2, 0, $urandom());

		// Fill the list to capacity, then probe the full list: a valid insert
		// position reports full, a bad one still reports out of range.
		while (list_len < DEPTH_DEF)
			send_request(CMD_INSERT, $urandom_range(1, list_len + 1), 0, $urandom());
		send_request(CMD_INSERT, 1, 0, $urandom());
		send_request(CMD_INSERT, DEPTH_DEF + 1, 0, $urandom());
		send_request(CMD_INSERT, DEPTH_DEF + 2, 0, $urandom());
		send_request(CMD_INSERT, 0, 0, $urandom());
		send_request(CMD_READ,   DEPTH_DEF, 0, $urandom());
		send_request(CMD_READ,   DEPTH_DEF + 1, 0, $urandom());
		send_request(CMD_SWAP,   1, DEPTH_DEF, $urandom());
		send_request(CMD_ERASE,  DEPTH_DEF, 0, $urandom());
		wait_for_replies();

		// Random phases with a fresh throttle mix each time. Phase three stalls
		// the result side for a long stretch under a steady stream of requests;
		// the last two phases run with no idling at all.
		for (p = 0; p < 11; p++) begin
			send_gaps = (p < 9) ? ($urandom_range(0, 1) != 0) : 1'b0;
			take_gaps = (p < 9) ? ($urandom_range(0, 1) != 0) : 1'b0;
			if (p == 3) begin
				send_gaps   = 1'b0;
				hold_output = 1'b1;
			end
			random_phase(plan[p], 100);
			if (p == 1 || p == 5)
				wait_for_replies();
		end

		wait_for_replies();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/plst_pkg.sv
hw/rtl/plst_cell.sv
hw/rtl/plst_select.sv
hw/rtl/positional_list_engine.sv
verif/list_engine_checker.sv
verif/tb.sv
